FILE: rtl/ctt_pkg.sv
// Shared types, character codes and token kinds for the config text tokenizer.
// Used by ctt_scan, ctt_queue and config_text_tokenizer_top; depends on nothing.
`default_nettype none

package ctt_pkg;

	// Width of the internal offset and length counters
	localparam int OFFSET_BITS = 16;
	localparam int FIELD_BITS  = 16;

	typedef logic [OFFSET_BITS-1:0] ofs_t;
	typedef logic [FIELD_BITS-1:0]  field_t;

	localparam ofs_t OFFSET_MAX = {OFFSET_BITS{1'b1}};

	// Result queue sizing
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCOUNT_W = $clog2(QDEPTH + 1);

	// Character codes
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_VTAB    = 8'h0B;
	localparam logic [7:0] CH_FFEED   = 8'h0C;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_EQUAL   = 8'h3D;
	localparam logic [7:0] CH_LBRACK  = 8'h5B;
	localparam logic [7:0] CH_RBRACK  = 8'h5D;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_USCORE  = 8'h5F;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;

	typedef enum logic [2:0] {
		MODE_NORMAL  = 3'd0,
		MODE_IDENT   = 3'd1,
		MODE_STRING  = 3'd2,
		MODE_COMMENT = 3'd3,
		MODE_HALTED  = 3'd4
	} scan_mode_t;

	typedef enum logic [3:0] {
		KIND_IDENT    = 4'd0,
		KIND_STRING   = 4'd1,
		KIND_LBRACKET = 4'd2,
		KIND_RBRACKET = 4'd3,
		KIND_BSLASH   = 4'd4,
		KIND_EQUAL    = 4'd5,
		KIND_NEWLINE  = 4'd6,
		KIND_ERROR    = 4'd7,
		KIND_END      = 4'd8
	} token_kind_t;

	typedef struct packed {
		token_kind_t kind;
		field_t      start;
		field_t      length;
		logic        overflow;
		logic        last;
	} token_t;

	// Up to two tokens produced by one transaction
	typedef struct packed {
		logic [1:0] count;
		token_t     tok0;
		token_t     tok1;
	} scan_out_t;

endpackage

`default_nettype wire

FILE: rtl/ctt_scan.sv
// Per-byte scanner: mode and counter state plus the single-pass token logic.
// Depends on ctt_pkg.
`default_nettype none

module ctt_scan (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire logic [7:0]         text_byte,
	input  wire logic               end_of_text,
	output ctt_pkg::scan_out_t      res
);

	typedef struct packed {
		logic                 emit;
		ctt_pkg::token_kind_t kind;
		ctt_pkg::scan_mode_t  mode;
		logic                 pend;
	} normal_t;

	ctt_pkg::scan_mode_t mode_q, mode_d;
	ctt_pkg::ofs_t       pos_q, pos_d;
	ctt_pkg::ofs_t       start_q, start_d;
	ctt_pkg::ofs_t       len_q, len_d;
	logic                sat_q, sat_d;

	ctt_pkg::ofs_t       pos_inc, len_inc;
	logic                pos_max, len_max;
	logic                sat_b;
	normal_t             nr;
	logic                is_ident_char;

	// Classify one byte as seen outside any token
	function automatic normal_t classify(input logic [7:0] c);
		normal_t r;
		r.emit = 1'b0;
		r.kind = ctt_pkg::KIND_ERROR;
		r.mode = ctt_pkg::MODE_NORMAL;
		r.pend = 1'b0;
		if (c == ctt_pkg::CH_NEWLINE) begin
			r.emit = 1'b1;
			r.kind = ctt_pkg::KIND_NEWLINE;
		end else if (c inside {ctt_pkg::CH_SPACE, ctt_pkg::CH_TAB, ctt_pkg::CH_VTAB,
				ctt_pkg::CH_FFEED, ctt_pkg::CH_CR}) begin
			r.emit = 1'b0;
		end else if (c == ctt_pkg::CH_HASH) begin
			r.mode = ctt_pkg::MODE_COMMENT;
		end else if (c == ctt_pkg::CH_EQUAL) begin
			r.emit = 1'b1;
			r.kind = ctt_pkg::KIND_EQUAL;
		end else if (c == ctt_pkg::CH_LBRACK) begin
			r.emit = 1'b1;
			r.kind = ctt_pkg::KIND_LBRACKET;
		end else if (c == ctt_pkg::CH_RBRACK) begin
			r.emit = 1'b1;
			r.kind = ctt_pkg::KIND_RBRACKET;
		end else if (c == ctt_pkg::CH_BSLASH) begin
			r.emit = 1'b1;
			r.kind = ctt_pkg::KIND_BSLASH;
		end else if (c == ctt_pkg::CH_QUOTE) begin
			r.mode = ctt_pkg::MODE_STRING;
			r.pend = 1'b1;
		end else if (c inside {[ctt_pkg::CH_LOWER_A:ctt_pkg::CH_LOWER_Z],
				[ctt_pkg::CH_UPPER_A:ctt_pkg::CH_UPPER_Z]}) begin
			r.mode = ctt_pkg::MODE_IDENT;
			r.pend = 1'b1;
		end else begin
			r.emit = 1'b1;
			r.kind = ctt_pkg::KIND_ERROR;
			r.mode = ctt_pkg::MODE_HALTED;
		end
		return r;
	endfunction

	function automatic ctt_pkg::token_t mk_token(
		input ctt_pkg::token_kind_t kind,
		input ctt_pkg::ofs_t        start,
		input ctt_pkg::ofs_t        length,
		input logic                 ovf
	);
		ctt_pkg::token_t t;
		t.kind     = kind;
		t.start    = ctt_pkg::FIELD_BITS'(start);
		t.length   = ctt_pkg::FIELD_BITS'(length);
		t.overflow = ovf;
		t.last     = 1'b0;
		return t;
	endfunction

	// Saturating increments
	assign pos_max = (pos_q == ctt_pkg::OFFSET_MAX);
	assign len_max = (len_q == ctt_pkg::OFFSET_MAX);
	assign pos_inc = pos_max ? pos_q : pos_q + ctt_pkg::ofs_t'(1);
	assign len_inc = len_max ? len_q : len_q + ctt_pkg::ofs_t'(1);

	assign nr = classify(text_byte);
	assign is_ident_char = (text_byte inside {[ctt_pkg::CH_LOWER_A:ctt_pkg::CH_LOWER_Z],
		[ctt_pkg::CH_UPPER_A:ctt_pkg::CH_UPPER_Z],
		[ctt_pkg::CH_DIGIT_0:ctt_pkg::CH_DIGIT_9], ctt_pkg::CH_USCORE});

	// Work out the tokens and the next state for the current byte
	always_comb begin
		res.count = 2'd0;
		res.tok0  = mk_token(ctt_pkg::KIND_END, pos_q, '0, sat_q);
		res.tok1  = mk_token(ctt_pkg::KIND_END, pos_q, '0, sat_q);
		mode_d    = mode_q;
		pos_d     = pos_q;
		start_d   = start_q;
		len_d     = len_q;
		sat_b     = sat_q;
		sat_d     = sat_q;
		if (end_of_text) begin
			if (mode_q == ctt_pkg::MODE_IDENT) begin
				res.tok0  = mk_token(ctt_pkg::KIND_IDENT, start_q, len_q, sat_q);
				res.count = 2'd2;
			end else begin
				res.count = 2'd1;
			end
			mode_d  = ctt_pkg::MODE_NORMAL;
			pos_d   = '0;
			start_d = '0;
			len_d   = '0;
			sat_d   = 1'b0;
		end else begin
			case (mode_q)
				ctt_pkg::MODE_COMMENT: begin
					if (text_byte == ctt_pkg::CH_NEWLINE)
						mode_d = ctt_pkg::MODE_NORMAL;
				end
				ctt_pkg::MODE_STRING: begin
					len_d = len_inc;
					sat_b = sat_q | len_max;
					if (text_byte == ctt_pkg::CH_QUOTE) begin
						res.tok0  = mk_token(ctt_pkg::KIND_STRING, start_q, len_inc, sat_b);
						res.count = 2'd1;
						mode_d    = ctt_pkg::MODE_NORMAL;
					end
				end
				ctt_pkg::MODE_HALTED: begin
					mode_d = ctt_pkg::MODE_HALTED;
				end
				ctt_pkg::MODE_IDENT: begin
					if (is_ident_char) begin
						len_d = len_inc;
						sat_b = sat_q | len_max;
					end else begin
						res.tok0  = mk_token(ctt_pkg::KIND_IDENT, start_q, len_q, sat_q);
						res.tok1  = mk_token(nr.kind, pos_q, ctt_pkg::ofs_t'(1), sat_q);
						res.count = nr.emit ? 2'd2 : 2'd1;
						mode_d    = nr.mode;
						if (nr.pend) begin
							start_d = pos_q;
							len_d   = ctt_pkg::ofs_t'(1);
						end
					end
				end
				default: begin
					res.tok0  = mk_token(nr.kind, pos_q, ctt_pkg::ofs_t'(1), sat_q);
					res.count = nr.emit ? 2'd1 : 2'd0;
					mode_d    = nr.mode;
					if (nr.pend) begin
						start_d = pos_q;
						len_d   = ctt_pkg::ofs_t'(1);
					end
				end
			endcase
			pos_d = pos_inc;
			sat_d = sat_b | pos_max;
		end
		// Mark the final token of this transaction
		res.tok0.last = (res.count == 2'd1);
		res.tok1.last = 1'b1;
	end

	// Advance the scanner state when the byte is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= ctt_pkg::MODE_NORMAL;
			pos_q   <= '0;
			start_q <= '0;
			len_q   <= '0;
			sat_q   <= 1'b0;
		end else if (step) begin
			mode_q  <= mode_d;
			pos_q   <= pos_d;
			start_q <= start_d;
			len_q   <= len_d;
			sat_q   <= sat_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/ctt_queue.sv
// Small token queue: takes up to two tokens a cycle, hands out one a cycle while rd_stall is low.
// Depends on ctt_pkg.
`default_nettype none

module ctt_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                wr_en,
	input  wire ctt_pkg::scan_out_t  wr_data,
	output logic                     room,
	output logic                     rd_valid,
	input  wire logic                rd_stall,
	output ctt_pkg::token_t          rd_data
);

	ctt_pkg::token_t                mem_q [ctt_pkg::QDEPTH];
	logic [ctt_pkg::QPTR_W-1:0]     wp_q, rp_q;
	logic [ctt_pkg::QCOUNT_W-1:0]   count_q;
	logic [1:0]                     wr_n;
	logic                           rd_en;

	assign wr_n     = wr_en ? wr_data.count : 2'd0;
	assign rd_valid = (count_q != '0);
	assign rd_en    = rd_valid && !rd_stall;
	assign rd_data  = mem_q[rp_q];
	// Room for the worst case of two tokens
	assign room     = (count_q <= ctt_pkg::QCOUNT_W'(ctt_pkg::QDEPTH - 2));

	// Store the incoming tokens
	always_ff @(posedge clk) begin
		if (wr_n != 2'd0)
			mem_q[wp_q] <= wr_data.tok0;
		if (wr_n == 2'd2)
			mem_q[wp_q + ctt_pkg::QPTR_W'(1)] <= wr_data.tok1;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + ctt_pkg::QPTR_W'(wr_n);
			if (rd_en)
				rp_q <= rp_q + ctt_pkg::QPTR_W'(1);
			count_q <= count_q + ctt_pkg::QCOUNT_W'(wr_n)
				- ctt_pkg::QCOUNT_W'(rd_en);
		end
	end

endmodule

`default_nettype wire

FILE: rtl/config_text_tokenizer_top.sv
// Top level of the config text tokenizer: input register, scanner and token queue.
// Depends on ctt_pkg, ctt_scan and ctt_queue.
//
// Usage:
//   Text channel (text_valid/text_stall) carries one byte per transaction, or an
//   end-of-text marker (end_of_text = 1, text_byte ignored). Token channel
//   (token_valid/token_stall) carries one token per transaction: kind, start
//   offset, length, overflow and last_of_run on the final token of a byte.
//   A byte gives zero, one or two tokens; every text closes with an end token,
//   after which the block is ready for the next text.
// Path: a byte is taken into the input register, and once the queue has room
//   the scanner writes its tokens into the token queue; the byte's first token
//   is then offered from the queue head.
// Throughput: one byte per cycle, limited only by the token port, which moves one
//   token per cycle while token_stall is low; a two-token byte takes two transfers.
// Reset: arst_n clears the scanner to normal mode with all counters at zero
//   and empties the token queue.
// Stall: while token_stall is high tokens are held; the four-entry queue fills
//   and text_stall rises once it can no longer take a worst-case two tokens.
`default_nettype none

module config_text_tokenizer_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        text_valid,
	output logic             text_stall,
	input  wire logic [7:0]  text_byte,
	input  wire logic        end_of_text,
	output logic             token_valid,
	input  wire logic        token_stall,
	output logic [3:0]       token_kind,
	output logic [15:0]      token_start,
	output logic [15:0]      token_length,
	output logic             overflow,
	output logic             last_of_run
);

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                eot_s1;
	logic                room;
	logic                step;
	ctt_pkg::scan_out_t  scan_res;
	ctt_pkg::token_t     head;

	assign step       = valid_s1 && room;
	assign text_stall = valid_s1 && !room;

	// Input register: load a new transaction whenever the held one moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!text_stall) begin
			valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_valid && !text_stall) begin
			byte_s1 <= text_byte;
			eot_s1  <= end_of_text;
		end
	end

	ctt_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.text_byte   (byte_s1),
		.end_of_text (eot_s1),
		.res         (scan_res)
	);

	ctt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (step),
		.wr_data  (scan_res),
		.room     (room),
		.rd_valid (token_valid),
		.rd_stall (token_stall),
		.rd_data  (head)
	);

	// Drive the token ports from the queue head
	assign token_kind   = head.kind;
	assign token_start  = head.start;
	assign token_length = head.length;
	assign overflow     = head.overflow;
	assign last_of_run  = head.last;

endmodule

`default_nettype wire
